[rtl/cdq_pkg.sv]
package cdq_pkg;

   localparam int DEPTH  = 16;
   localparam int DATA_W = 32;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CAP_W  = 5;
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam int REQ_W = 40;
   localparam int RSP_W = 104;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_BACK  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_BACK   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   // Broadcast to every cell; at most one of the moves is set in a cycle.
   // drop_back shifts only the occupancy down, so the last occupied cell empties.
   typedef struct packed {
      logic clear;
      logic shift_up;
      logic load_back;
      logic shift_down;
      logic drop_back;
   } cell_ctrl_type;

endpackage

[rtl/circular_deque.sv]
// Double-ended queue of signed 32-bit words built as a row of DEPTH cells.
// The front always sits in cell 0; pushing at the front shifts the row up,
// popping at the front shifts it down, and the back end is the last occupied
// cell, found through a one-hot mask of the occupancy thermometer.
// req channel: one item per operation (push front, push back, pop front,
// pop back) with the word to push. rsp channel: exactly one item per request
// with the popped word, a status (ok, overflow, underflow), the new count and
// the new front and back words with a flag that they are meaningful.
// The response is registered and is valid in the cycle after accept. Every
// operation finishes in the same cycle it is accepted, so one item per
// cycle is sustained; the single output register sets that figure.
// When the receiver stalls, the response holds and req_tready drops until
// it is taken. csr channel writes the usable capacity (0 acts as 1, above
// DEPTH acts as DEPTH) and empties the deque; write it only while idle.
// Reset empties the deque and sets the capacity to 16. Cell contents are
// not cleared; only occupied cells are ever read.
module circular_deque
   import cdq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // [1:0] operation, [33:2] push_value, [39:34] zero
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // [31:0] popped_value, [33:32] status, [38:34] entry_count,
   // [70:39] front_value, [102:71] back_value, [103] ends_valid
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_data
);

   logic [CAP_W-1:0]  cap_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   logic              req_accept, csr_accept;
   op_type            op;
   logic [DATA_W-1:0] push_value;
   logic [CMP_W-1:0]  cap_eff;
   logic              empty, full, more_than_one;
   cell_ctrl_type     ctrl;

   logic [DATA_W-1:0] cell_data [DEPTH];
   logic [DATA_W-1:0] back_part [DEPTH];
   logic [DATA_W-1:0] prev_part [DEPTH];
   logic [DEPTH-1:0]  cell_occ;
   logic [DATA_W-1:0] back_cur, prev_cur;

   logic [DATA_W-1:0] popped_n, front_n, back_n;
   status_type        status_n;

   assign req_accept = req_tvalid && req_tready;
   assign csr_accept = csr_valid && csr_ready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   assign op         = op_type'(req_tdata[1:0]);
   assign push_value = req_tdata[33:2];

   always_comb begin
      cap_eff = CMP_W'(cap_ff);
      if (cap_ff == '0) begin
         cap_eff = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(DEPTH)) begin
         cap_eff = CMP_W'(DEPTH);
      end
   end

   assign empty         = (count_ff == '0);
   assign full          = (CMP_W'(count_ff) >= cap_eff);
   assign more_than_one = (count_ff > CNT_W'(1));

   // Row of cells.
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic [DATA_W-1:0] left_data, right_data;
      logic              left_occ, right_occ, right2_occ;

      if (k == 0) begin : g_first
         assign left_data = push_value;
         assign left_occ  = 1'b1;
      end else begin : g_mid_l
         assign left_data = cell_data[k-1];
         assign left_occ  = cell_occ[k-1];
      end

      if (k == DEPTH - 1) begin : g_last
         assign right_data = cell_data[k];
         assign right_occ  = 1'b0;
      end else begin : g_mid_r
         assign right_data = cell_data[k+1];
         assign right_occ  = cell_occ[k+1];
      end

      if (k >= DEPTH - 2) begin : g_end2
         assign right2_occ = 1'b0;
      end else begin : g_mid2
         assign right2_occ = cell_occ[k+2];
      end

      cdq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .push_value (push_value),
         .left_data  (left_data),
         .left_occ   (left_occ),
         .right_data (right_data),
         .right_occ  (right_occ),
         .right2_occ (right2_occ),
         .data       (cell_data[k]),
         .occ        (cell_occ[k]),
         .back_part  (back_part[k]),
         .prev_part  (prev_part[k])
      );
   end

   // Only one cell contributes to each of these at a time.
   always_comb begin
      back_cur = '0;
      prev_cur = '0;
      for (int k = 0; k < DEPTH; k++) begin
         back_cur = back_cur | back_part[k];
         prev_cur = prev_part[k] | prev_cur;
      end
   end

   always_comb begin
      ctrl       = '0;
      ctrl.clear = csr_accept;
      count_in   = count_ff;
      popped_n   = '0;
      status_n   = ST_OK;
      front_n    = cell_data[0];
      back_n     = back_cur;
      if (csr_accept) begin
         count_in = '0;
      end
      unique case (op)
         OP_PUSH_FRONT: begin
            if (full) begin
               status_n = ST_OVERFLOW;
            end else begin
               ctrl.shift_up = req_accept;
               front_n       = push_value;
               back_n        = empty ? push_value : back_cur;
               if (req_accept) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         OP_PUSH_BACK: begin
            if (full) begin
               status_n = ST_OVERFLOW;
            end else begin
               ctrl.load_back = req_accept;
               front_n        = empty ? push_value : cell_data[0];
               back_n         = push_value;
               if (req_accept) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               status_n = ST_UNDERFLOW;
               front_n  = '0;
               back_n   = '0;
            end else begin
               ctrl.shift_down = req_accept;
               popped_n        = cell_data[0];
               front_n         = more_than_one ? cell_data[1] : '0;
               back_n          = more_than_one ? back_cur : '0;
               if (req_accept) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               status_n = ST_UNDERFLOW;
               front_n  = '0;
               back_n   = '0;
            end else begin
               // Popping the back only clears the last occupied cell, which a
               // downward occupancy shift does without moving any data.
               ctrl.drop_back = req_accept;
               popped_n       = back_cur;
               front_n        = more_than_one ? cell_data[0] : '0;
               back_n         = more_than_one ? prev_cur : '0;
               if (req_accept) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         default: begin
            status_n = ST_OK;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {(count_in != '0), back_n, front_n,
                         5'(count_in), status_n, popped_n};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_accept) begin
            cap_ff <= csr_data;
         end
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_occ) == int'(count_ff))
      else $error("entry count disagrees with occupied cells");

   a_occ_thermometer: assert property (@(posedge clock) disable iff (reset)
      ((cell_occ & (cell_occ + DEPTH'(1))) == '0))
      else $error("cell occupancy is not contiguous from the front");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= cap_eff || $past(csr_accept))
      else $error("entry count above usable capacity");

   a_push_empty_ok: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !req_tdata[1] && empty) |=>
         (rsp_tdata[33:32] == ST_OK && rsp_tdata[103]))
      else $error("push into an empty deque did not succeed");

   a_ends_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[103] == (rsp_tdata[38:34] != '0)))
      else $error("ends_valid disagrees with entry_count");

endmodule

[rtl/cdq_cell.sv]
module cdq_cell
   import cdq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cell_ctrl_type     ctrl,
   input  logic [DATA_W-1:0] push_value,
   input  logic [DATA_W-1:0] left_data,
   input  logic              left_occ,
   input  logic [DATA_W-1:0] right_data,
   input  logic              right_occ,
   input  logic              right2_occ,
   output logic [DATA_W-1:0] data,
   output logic              occ,
   output logic [DATA_W-1:0] back_part,
   output logic [DATA_W-1:0] prev_part
);

   logic [DATA_W-1:0] data_ff, data_in;
   logic              occ_ff, occ_in;

   // Occupancy is a thermometer code: growing pulls from the left, shrinking from the right.
   always_comb begin
      occ_in = occ_ff;
      if (ctrl.clear) begin
         occ_in = 1'b0;
      end else if (ctrl.shift_up || ctrl.load_back) begin
         occ_in = left_occ;
      end else if (ctrl.shift_down || ctrl.drop_back) begin
         occ_in = right_occ;
      end
   end

   always_comb begin
      data_in = data_ff;
      if (ctrl.shift_up) begin
         data_in = left_data;
      end else if (ctrl.load_back && !occ_ff && left_occ) begin
         data_in = push_value;
      end else if (ctrl.shift_down) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data      = data_ff;
   assign occ       = occ_ff;
   assign back_part = (occ_ff && !right_occ) ? data_ff : '0;
   assign prev_part = (right_occ && !right2_occ) ? data_ff : '0;

endmodule

[sim/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cdq_pkg::*;

   // Same layout as rsp_tdata: popped_value sits in the lowest bits.
   typedef struct packed {
      logic                     ends_valid;
      logic signed [DATA_W-1:0] back_value;
      logic signed [DATA_W-1:0] front_value;
      logic [CNT_W-1:0]         entry_count;
      status_type               status;
      logic signed [DATA_W-1:0] popped_value;
   } deque_rsp_type;

   typedef struct packed {
      logic              is_cfg;
      logic [CAP_W-1:0]  cfg_value;
      op_type            op;
      logic [DATA_W-1:0] push_value;
      logic              has_known;
      deque_rsp_type     rsp;
   } dir_row_type;

   localparam int N_DIR    = 26;
   localparam int N_PHASES = 10;
   localparam int PHASE_N  = 85;

   logic             clock;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic [CAP_W-1:0] csr_data   = '0;

   // Predictor state: the words held, front first, and the capacity register.
   logic signed [DATA_W-1:0] deque_words[$];
   logic [CAP_W-1:0]         capacity_reg = CAP_RESET;
   deque_rsp_type            rsp_expect_q[$];

   bit          sender_idle = 1'b1;
   int unsigned mismatches  = 0;
   int unsigned ops_sent    = 0;
   int unsigned results_seen = 0;
   int unsigned overflows   = 0;
   int unsigned underflows  = 0;
   int unsigned cap_writes  = 0;

   dir_row_type dir_rows [N_DIR];

   circular_deque dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb NOT OK");
      $finish;
   end

   // A bounded deque behaves the same as the row of cells seen from outside.
   function automatic deque_rsp_type apply_operation(op_type op, logic signed [DATA_W-1:0] v);
      deque_rsp_type r;
      int            usable;
      r = '0;
      r.status = ST_OK;
      usable = (capacity_reg == 0) ? 1 : (capacity_reg > DEPTH) ? DEPTH : int'(capacity_reg);
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (deque_words.size() >= usable)
               r.status = ST_OVERFLOW;
            else if (op == OP_PUSH_FRONT)
               deque_words.insert(0, v);
            else
               deque_words.insert(deque_words.size(), v);
         end
         default: begin
            if (deque_words.size() == 0) begin
               r.status = ST_UNDERFLOW;
            end else if (op == OP_POP_FRONT) begin
               r.popped_value = deque_words[0];
               deque_words.delete(0);
            end else begin
               r.popped_value = deque_words[deque_words.size() - 1];
               deque_words.delete(deque_words.size() - 1);
            end
         end
      endcase
      r.entry_count = CNT_W'(deque_words.size());
      if (deque_words.size() != 0) begin
         r.front_value = deque_words[0];
         r.back_value  = deque_words[$];
         r.ends_valid  = 1'b1;
      end
      return r;
   endfunction

   function automatic deque_rsp_type rsp_of(logic [DATA_W-1:0] popped, status_type st,
                                            logic [CNT_W-1:0] cnt, logic [DATA_W-1:0] f,
                                            logic [DATA_W-1:0] b, logic ev);
      deque_rsp_type r;
      r.popped_value = popped;
      r.status       = st;
      r.entry_count  = cnt;
      r.front_value  = f;
      r.back_value   = b;
      r.ends_valid   = ev;
      return r;
   endfunction

   function automatic dir_row_type op_row(op_type op, logic [DATA_W-1:0] v);
      dir_row_type r;
      r = '0;
      r.op = op;
      r.push_value = v;
      return r;
   endfunction

   function automatic dir_row_type known_row(op_type op, logic [DATA_W-1:0] v,
                                             deque_rsp_type want);
      dir_row_type r;
      r = op_row(op, v);
      r.has_known = 1'b1;
      r.rsp = want;
      return r;
   endfunction

   function automatic dir_row_type cap_row(logic [CAP_W-1:0] c);
      dir_row_type r;
      r = '0;
      r.is_cfg = 1'b1;
      r.cfg_value = c;
      return r;
   endfunction

   function automatic void compare_field(string name, logic [DATA_W-1:0] want,
                                         logic [DATA_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void check_result(deque_rsp_type got);
      deque_rsp_type want;
      if (rsp_expect_q.size() == 0) begin
         $display("%0t: result with nothing expected, expected none, actual %p", $time, got);
         mismatches++;
         return;
      end
      want = rsp_expect_q[0];
      rsp_expect_q.delete(0);
      compare_field("popped_value", want.popped_value, got.popped_value);
      compare_field("status", DATA_W'(want.status), DATA_W'(got.status));
      compare_field("entry_count", DATA_W'(want.entry_count), DATA_W'(got.entry_count));
      compare_field("front_value", want.front_value, got.front_value);
      compare_field("back_value", want.back_value, got.back_value);
      compare_field("ends_valid", DATA_W'(want.ends_valid), DATA_W'(got.ends_valid));
   endfunction

   task automatic send_item(op_type op, logic [DATA_W-1:0] v, logic has_known,
                            deque_rsp_type known);
      int            gap;
      deque_rsp_type predicted;
      gap = sender_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({v, op});
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      predicted = apply_operation(op, v);
      rsp_expect_q.insert(rsp_expect_q.size(), has_known ? known : predicted);
      ops_sent++;
      if (predicted.status == ST_OVERFLOW) overflows++;
      if (predicted.status == ST_UNDERFLOW) underflows++;
   endtask

   // Holds the sender back until every item sent has produced its result.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (rsp_expect_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] c);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= c;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      csr_valid <= 1'b0;
      capacity_reg = c;
      deque_words.delete();
      cap_writes++;
   endtask

   // Result side: random stalls, with stretches of none.
   initial begin
      int  stall;
      bit  rx_idle;
      rx_idle = 1'b1;
      while (reset) @(posedge clock);
      forever begin
         if (results_seen % 40 == 0) rx_idle = ($urandom_range(0, 2) != 0);
         stall = rx_idle ? $urandom_range(0, 7) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (rsp_tvalid !== 1'b1) @(posedge clock);
         check_result(deque_rsp_type'(rsp_tdata));
         results_seen++;
      end
   end

   initial begin
      logic [CAP_W-1:0]  cap_plan [N_PHASES];
      op_type            op;
      logic [DATA_W-1:0] value;
      int                push_pct;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      dir_rows = '{
         known_row(OP_POP_FRONT, 32'h0,
                   rsp_of(32'h0, ST_UNDERFLOW, 5'd0, 32'h0, 32'h0, 1'b0)),
         known_row(OP_POP_BACK, 32'h0,
                   rsp_of(32'h0, ST_UNDERFLOW, 5'd0, 32'h0, 32'h0, 1'b0)),
         known_row(OP_PUSH_BACK, 32'h7fff_ffff,
                   rsp_of(32'h0, ST_OK, 5'd1, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1)),
         known_row(OP_PUSH_FRONT, 32'h8000_0000,
                   rsp_of(32'h0, ST_OK, 5'd2, 32'h8000_0000, 32'h7fff_ffff, 1'b1)),
         op_row(OP_PUSH_FRONT, 32'hffff_ffff),
         op_row(OP_PUSH_BACK, 32'h0),
         op_row(OP_POP_BACK, 32'hdead_beef),
         op_row(OP_POP_FRONT, 32'h0),
         op_row(OP_POP_FRONT, 32'h0),
         op_row(OP_POP_BACK, 32'h0),
         op_row(OP_PUSH_FRONT, 32'h5555_5555),
         op_row(OP_PUSH_BACK, 32'haaaa_aaaa),
         cap_row(5'd0),
         known_row(OP_PUSH_FRONT, 32'h1234_5678,
                   rsp_of(32'h0, ST_OK, 5'd1, 32'h1234_5678, 32'h1234_5678, 1'b1)),
         known_row(OP_PUSH_BACK, 32'h1,
                   rsp_of(32'h0, ST_OVERFLOW, 5'd1, 32'h1234_5678, 32'h1234_5678, 1'b1)),
         known_row(OP_POP_BACK, 32'h0,
                   rsp_of(32'h1234_5678, ST_OK, 5'd0, 32'h0, 32'h0, 1'b0)),
         known_row(OP_POP_FRONT, 32'h0,
                   rsp_of(32'h0, ST_UNDERFLOW, 5'd0, 32'h0, 32'h0, 1'b0)),
         cap_row(5'd2),
         op_row(OP_PUSH_BACK, 32'h0f0f_0f0f),
         op_row(OP_PUSH_FRONT, 32'hf0f0_f0f0),
         known_row(OP_PUSH_BACK, 32'h3,
                   rsp_of(32'h0, ST_OVERFLOW, 5'd2, 32'hf0f0_f0f0, 32'h0f0f_0f0f, 1'b1)),
         op_row(OP_POP_FRONT, 32'h0),
         op_row(OP_PUSH_BACK, 32'h1),
         op_row(OP_POP_BACK, 32'h0),
         op_row(OP_POP_BACK, 32'h0),
         op_row(OP_POP_BACK, 32'h0)
      };

      for (int i = 0; i < N_DIR; i++) begin
         if (dir_rows[i].is_cfg)
            write_capacity(dir_rows[i].cfg_value);
         else
            send_item(dir_rows[i].op, dir_rows[i].push_value, dir_rows[i].has_known,
                      dir_rows[i].rsp);
      end

      // Out-of-range capacities are in the plan on purpose: 0, 31 and one from 17 to 30.
      cap_plan = '{5'd16, 5'd1, 5'd31, 5'd2, 5'd16, 5'd0, 5'd3, 5'd17, 5'd16, 5'd8};
      cap_plan[6] = CAP_W'($urandom_range(3, 15));
      cap_plan[7] = CAP_W'($urandom_range(17, 30));

      for (int p = 0; p < N_PHASES; p++) begin
         write_capacity(cap_plan[p]);
         push_pct = 85;
         for (int k = 0; k < PHASE_N; k++) begin
            // Alternate filling and draining blocks so full and empty are both reached.
            if (k % 32 == 0) begin
               sender_idle = ($urandom_range(0, 3) != 0);
               push_pct = ((k / 32) % 2 == 0) ? 85 : 20;
            end
            if (p == 4 && k == 40) wait_drained();
            if ($urandom_range(0, 99) < push_pct)
               op = op_type'($urandom_range(0, 1));
            else
               op = op_type'($urandom_range(2, 3));
            case ($urandom_range(0, 15))
               0: value = 32'h8000_0000;
               1: value = 32'h7fff_ffff;
               2: value = 32'h0;
               3: value = 32'hffff_ffff;
               default: value = $urandom;
            endcase
            send_item(op, value, 1'b0, '0);
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);

      $display("Sent %0d operations over %0d capacity settings, %0d overflows, %0d underflows.",
               ops_sent, cap_writes, overflows, underflows);
      $display("Checked %0d results, %0d field mismatches.", results_seen, mismatches);
      if (mismatches == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

[filelist.f]
rtl/cdq_pkg.sv
rtl/cdq_cell.sv
rtl/circular_deque.sv
sim/tb.sv
